### rtl/wsfd_pkg.sv
package wsfd_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_e;

  // Result kinds, carried on tuser
  typedef enum logic [1:0] {
    EV_PAYLOAD   = 2'd0,
    EV_EMPTY     = 2'd1,
    EV_CLOSE     = 2'd2,
    EV_TOO_LARGE = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    FC_DROP    = 2'd0,
    FC_DELIVER = 2'd1,
    FC_CLOSE   = 2'd2
  } frame_class_e;

  // Opcodes that matter to the parser
  localparam logic [3:0] OPC_CONT   = 4'h0;
  localparam logic [3:0] OPC_TEXT   = 4'h1;
  localparam logic [3:0] OPC_BINARY = 4'h2;
  localparam logic [3:0] OPC_CLOSE  = 4'h8;
  localparam logic [3:0] OPC_PING   = 4'h9;
  localparam logic [3:0] OPC_PONG   = 4'hA;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;

  localparam int unsigned EXT16_BYTES = 2;
  localparam int unsigned EXT64_BYTES = 8;
  localparam int unsigned KEY_BYTES   = 4;

  // Configuration register indexes
  localparam logic CFG_LIMIT_ENABLE   = 1'b0;
  localparam logic CFG_MAX_FRAME_SIZE = 1'b1;

  localparam int unsigned MAX_SIZE_W = 31;
  localparam int unsigned OUT_DATA_W = 32;

  typedef struct packed {
    logic        valid;
    event_e      kind;
    logic [7:0]  payload_byte;
    logic [3:0]  opcode;
    logic        final_flag;
    logic        frame_end;
    logic [15:0] close_code;
    logic        close_code_valid;
  } result_t;

endpackage

### rtl/wsfd_parser.sv
module wsfd_parser import wsfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [MAX_SIZE_W-1:0] cfg_data_i,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output result_t               res_o
);

  logic                  limit_q, limit_d;
  logic [MAX_SIZE_W-1:0] max_q, max_d;

  phase_e      phase_q, phase_d;
  logic [3:0]  hidx_q, hidx_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic        mask_q, mask_d;
  logic [1:0]  mphase_q, mphase_d;
  logic        fin_q, fin_d;
  logic [3:0]  opc_q, opc_d;
  logic        closing_q, closing_d;
  logic        err_q, err_d;
  logic [15:0] accum_q, accum_d;
  logic [1:0]  cbs_q, cbs_d;

  frame_class_e cls;
  logic [63:0]  rem_shift;
  logic [63:0]  rem_dec;
  logic [3:0]   hidx_inc;
  logic         len_chk;
  logic [63:0]  len_val;
  logic         too_big;
  logic         hdr_fin;
  logic [63:0]  hdr_len;
  logic [7:0]   key_byte;
  logic [7:0]   data;
  logic         last;
  logic [1:0]   cbs_new;
  logic [15:0]  accum_new;

  always_comb begin
    if (closing_q) begin
      cls = FC_DROP;
    end else begin
      unique case (opc_q)
        OPC_CONT, OPC_TEXT, OPC_BINARY, OPC_PING, OPC_PONG: cls = FC_DELIVER;
        OPC_CLOSE: cls = FC_CLOSE;
        default:   cls = FC_DROP;
      endcase
    end
  end

  assign rem_shift = {rem_q[55:0], byte_i};
  assign rem_dec   = (rem_q != 64'd0) ? rem_q - 64'd1 : rem_q;
  assign hidx_inc  = hidx_q + 4'd1;
  assign last      = (rem_dec == 64'd0);

  always_comb begin
    unique case (mphase_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign data = mask_q ? (byte_i ^ key_byte) : byte_i;

  always_comb begin
    limit_d = limit_q;
    max_d   = max_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LIMIT_ENABLE:   limit_d = cfg_data_i[0];
        CFG_MAX_FRAME_SIZE: max_d   = cfg_data_i;
        default:            limit_d = limit_q;
      endcase
    end
  end

  assign too_big = limit_q &&
                   ((|len_val[63:MAX_SIZE_W]) || (len_val[MAX_SIZE_W-1:0] > max_q));

  always_comb begin
    phase_d   = phase_q;
    hidx_d    = hidx_q;
    rem_d     = rem_q;
    key_d     = key_q;
    mask_d    = mask_q;
    mphase_d  = mphase_q;
    fin_d     = fin_q;
    opc_d     = opc_q;
    closing_d = closing_q;
    err_d     = err_q;
    accum_d   = accum_q;
    cbs_d     = cbs_q;
    res_o     = '0;
    len_chk   = 1'b0;
    len_val   = rem_shift;
    hdr_fin   = 1'b0;
    hdr_len   = rem_q;
    accum_new = {accum_q[7:0], data};
    cbs_new   = cbs_q;

    if (step_i && !err_q) begin
      unique case (phase_q)
        PH_HDR0: begin
          fin_d   = byte_i[7];
          opc_d   = byte_i[3:0];
          accum_d = '0;
          cbs_d   = '0;
          phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          mask_d = byte_i[7];
          hidx_d = '0;
          rem_d  = '0;
          if (byte_i[6:0] < LEN7_EXT16) begin
            rem_d   = {57'd0, byte_i[6:0]};
            len_val = {57'd0, byte_i[6:0]};
            len_chk = 1'b1;
          end else if (byte_i[6:0] == LEN7_EXT16) begin
            phase_d = PH_EXT16;
          end else begin
            phase_d = PH_EXT64;
          end
        end
        PH_EXT16, PH_EXT64: begin
          rem_d  = rem_shift;
          hidx_d = hidx_inc;
          if (hidx_inc >= ((phase_q == PH_EXT16) ? 4'(EXT16_BYTES) : 4'(EXT64_BYTES))) begin
            len_chk = 1'b1;
          end
        end
        PH_MASK: begin
          key_d  = {key_q[23:0], byte_i};
          hidx_d = hidx_inc;
          if (hidx_inc >= 4'(KEY_BYTES)) begin
            hdr_fin = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          mphase_d = mphase_q + 2'd1;
          rem_d    = rem_dec;
          if (last) begin
            phase_d = PH_HDR0;
          end
          if (cls == FC_DELIVER) begin
            res_o.valid        = 1'b1;
            res_o.kind         = EV_PAYLOAD;
            res_o.payload_byte = data;
            res_o.frame_end    = last;
          end else if (cls == FC_CLOSE) begin
            if (cbs_q < 2'd2) begin
              accum_d = accum_new;
              cbs_new = cbs_q + 2'd1;
              cbs_d   = cbs_new;
            end
            if (last) begin
              closing_d       = 1'b1;
              res_o.valid     = 1'b1;
              res_o.kind      = EV_CLOSE;
              res_o.frame_end = 1'b1;
              if (cbs_new >= 2'd2) begin
                res_o.close_code       = (cbs_q < 2'd2) ? accum_new : accum_q;
                res_o.close_code_valid = 1'b1;
              end
            end
          end
        end
        default: phase_d = PH_HDR0;
      endcase

      // length complete: limit check, then mask key or end of header
      if (len_chk) begin
        if (too_big) begin
          err_d           = 1'b1;
          res_o.valid     = 1'b1;
          res_o.kind      = EV_TOO_LARGE;
          res_o.frame_end = 1'b1;
        end else begin
          hidx_d = '0;
          if (mask_d) begin
            phase_d = PH_MASK;
          end else begin
            hdr_fin = 1'b1;
            hdr_len = len_val;
          end
        end
      end

      if (hdr_fin) begin
        mphase_d = '0;
        if (hdr_len != 64'd0) begin
          phase_d = PH_PAYLOAD;
        end else begin
          phase_d = PH_HDR0;
          if (cls == FC_DELIVER) begin
            res_o.valid     = 1'b1;
            res_o.kind      = EV_EMPTY;
            res_o.frame_end = 1'b1;
          end else if (cls == FC_CLOSE) begin
            closing_d       = 1'b1;
            res_o.valid     = 1'b1;
            res_o.kind      = EV_CLOSE;
            res_o.frame_end = 1'b1;
          end
        end
      end
    end

    if (res_o.valid) begin
      res_o.opcode     = opc_q;
      res_o.final_flag = fin_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= 1'b0;
      max_q     <= '0;
      phase_q   <= PH_HDR0;
      hidx_q    <= '0;
      rem_q     <= '0;
      key_q     <= '0;
      mask_q    <= 1'b0;
      mphase_q  <= '0;
      fin_q     <= 1'b0;
      opc_q     <= '0;
      closing_q <= 1'b0;
      err_q     <= 1'b0;
      accum_q   <= '0;
      cbs_q     <= '0;
    end else begin
      limit_q   <= limit_d;
      max_q     <= max_d;
      phase_q   <= phase_d;
      hidx_q    <= hidx_d;
      rem_q     <= rem_d;
      key_q     <= key_d;
      mask_q    <= mask_d;
      mphase_q  <= mphase_d;
      fin_q     <= fin_d;
      opc_q     <= opc_d;
      closing_q <= closing_d;
      err_q     <= err_d;
      accum_q   <= accum_d;
      cbs_q     <= cbs_d;
    end
  end

endmodule

### rtl/wsfd_out_reg.sv
module wsfd_out_reg import wsfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  result_t               res_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [OUT_DATA_W-1:0] data_o,
  output logic [1:0]            user_o,
  output logic                  last_o
);

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  // upstream may step whenever the register is empty or the held result leaves in this cycle
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (res_i.valid) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign data_o  = {2'b00, res_q.close_code_valid, res_q.close_code, res_q.final_flag,
                    res_q.opcode, res_q.payload_byte};
  assign user_o  = res_q.kind;
  assign last_o  = res_q.frame_end;

endmodule

### rtl/websocket_frame_deframer_unit.sv
// WebSocket receive-side deframer.
// s_axis carries the received byte stream, one byte per transfer. m_axis
// carries one result per payload byte or empty frame of a data, ping or
// pong frame, one for a completed close frame and one for an oversize
// frame; after a close only oversize results follow. tuser gives the
// result kind (payload, empty frame, close, too large); tlast marks the last result of a frame.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0 limit enable, 1 maximum frame size); the user must do so only while
// the block is idle; the block does not enforce it. Throughput: one byte
// per clock while m_axis does not stall. Header parsing, the length check,
// the 64-bit length countdown and unmasking sit between the parser state
// and the output register; a result shows on m_axis the cycle after its byte.
// When m_axis stalls the output register holds its result and s_axis_tready
// drops; it rises again in the cycle the result is taken.
// Reset clears the parser to the first header byte, clears the close and
// error flags, and resets both configuration registers to zero. After a
// too-large error all input is taken and dropped until reset.
module websocket_frame_deframer_unit import wsfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [MAX_SIZE_W-1:0] cfg_data_i,
  input  logic [7:0]            s_axis_tdata,   // data_byte
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] payload_byte, [11:8] frame_opcode, [12] final_flag,
  // [28:13] close_code, [29] close_code_valid, [31:30] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]            m_axis_tuser,   // event_kind
  output logic                  m_axis_tlast,   // frame_end
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready
);

  result_t res;
  logic    step;

  assign step = s_axis_tvalid && s_axis_tready;

  wsfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .byte_i      (s_axis_tdata),
    .res_o       (res)
  );

  wsfd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .ready_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata),
    .user_o  (m_axis_tuser),
    .last_o  (m_axis_tlast)
  );

endmodule
